>>> rtl/tltss_pkg.sv
package tltss_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VAL_W      = 32;
    localparam int OP_W       = 3;

    // op codes
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND_A = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND_B = 3'd2;
    localparam logic [OP_W-1:0] OP_APPEND_C = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] target;
    } t_in_item;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] b_value;
        logic signed [VAL_W-1:0] c_value;
        logic signed [VAL_W-1:0] a_value;
        logic                    overflow;
    } t_out_item;

endpackage

>>> rtl/tltss_ram.sv
module tltss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/three_list_triplet_sum_search.sv
// appends and clears: one item per cycle, no result item
// search: walks b (outer), c, then a, one a entry per cycle through the list rams;
//   result once the whole walk is done in the worst case, earlier on a hit
// input stalls while a search runs or its result waits for the output register
// reset (synchronous, active low) empties the lists and clears the sticky overflow flag
module three_list_triplet_sum_search
    import tltss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state;

    // list fill counts and sticky overflow
    logic [CNT_W-1:0] r_count_a;
    logic [CNT_W-1:0] r_count_b;
    logic [CNT_W-1:0] r_count_c;
    logic             r_overflow;

    // search walk indexes: i over b, j over c, k over a
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic             r_issue;
    logic signed [VAL_W-1:0] r_target;

    // pipeline: p1 = ram data out, p2 = remainder registered
    logic             r_p1_v;
    logic             r_p2_v;
    logic [VAL_W+1:0] r_rem;
    logic [VAL_W-1:0] r_b;
    logic [VAL_W-1:0] r_c;
    logic [VAL_W-1:0] r_a;

    // held search result
    logic             r_found;
    logic [VAL_W-1:0] r_res_b;
    logic [VAL_W-1:0] r_res_c;
    logic [VAL_W-1:0] r_res_a;

    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_accept;
    logic             we_a;
    logic             we_b;
    logic             we_c;
    logic             full_a;
    logic             full_b;
    logic             full_c;
    logic [VAL_W-1:0] rd_a;
    logic [VAL_W-1:0] rd_b;
    logic [VAL_W-1:0] rd_c;
    logic [IDX_W-1:0] last_a;
    logic [IDX_W-1:0] last_b;
    logic [IDX_W-1:0] last_c;
    logic [CNT_W-1:0] cnt_a_m1;
    logic [CNT_W-1:0] cnt_b_m1;
    logic [CNT_W-1:0] cnt_c_m1;
    logic [VAL_W+1:0] sum_bc;
    logic [VAL_W+1:0] rem;
    logic             hit;
    logic             any_empty;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign full_a = (r_count_a == CNT_W'(LIST_DEPTH));
    assign full_b = (r_count_b == CNT_W'(LIST_DEPTH));
    assign full_c = (r_count_c == CNT_W'(LIST_DEPTH));

    // append decode; a full list drops the value
    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        we_c = 1'b0;
        if (in_accept) begin
            unique case (i_in.op)
                OP_APPEND_A: we_a = !full_a;
                OP_APPEND_B: we_b = !full_b;
                OP_APPEND_C: we_c = !full_c;
                default: ;
            endcase
        end
    end

    tltss_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_count_a[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_k),
        .o_rdata (rd_a)
    );

    tltss_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_count_b[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_i),
        .o_rdata (rd_b)
    );

    tltss_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (we_c),
        .i_waddr (r_count_c[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_j),
        .o_rdata (rd_c)
    );

    // last valid index of each list (only used when the list is not empty)
    assign cnt_a_m1 = r_count_a - CNT_W'(1);
    assign cnt_b_m1 = r_count_b - CNT_W'(1);
    assign cnt_c_m1 = r_count_c - CNT_W'(1);
    assign last_a   = cnt_a_m1[IDX_W-1:0];
    assign last_b   = cnt_b_m1[IDX_W-1:0];
    assign last_c   = cnt_c_m1[IDX_W-1:0];

    assign any_empty = (r_count_a == '0) || (r_count_b == '0) || (r_count_c == '0);

    // full-width remainder, never wraps: target - (b + c) fits in 34 bits
    assign sum_bc = {{2{rd_b[VAL_W-1]}}, rd_b} + {{2{rd_c[VAL_W-1]}}, rd_c};
    assign rem    = {{2{r_target[VAL_W-1]}}, r_target} - sum_bc;

    // an out-of-range remainder cannot equal any sign-extended a entry
    assign hit = r_p2_v && (r_rem == {{2{r_a[VAL_W-1]}}, r_a});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_count_c   <= '0;
            r_overflow  <= 1'b0;
            r_issue     <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            // result taken downstream
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // remainder stage, runs freely behind the address walk
            r_p1_v <= r_issue;
            r_p2_v <= r_p1_v;
            r_rem  <= rem;
            r_b    <= rd_b;
            r_c    <= rd_c;
            r_a    <= rd_a;

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (i_in.op)
                            OP_CLEAR: begin
                                // overflow stays sticky across a clear
                                r_count_a <= '0;
                                r_count_b <= '0;
                                r_count_c <= '0;
                            end
                            OP_APPEND_A: begin
                                if (full_a) r_overflow <= 1'b1;
                                else        r_count_a  <= r_count_a + CNT_W'(1);
                            end
                            OP_APPEND_B: begin
                                if (full_b) r_overflow <= 1'b1;
                                else        r_count_b  <= r_count_b + CNT_W'(1);
                            end
                            OP_APPEND_C: begin
                                if (full_c) r_overflow <= 1'b1;
                                else        r_count_c  <= r_count_c + CNT_W'(1);
                            end
                            OP_SEARCH: begin
                                r_target <= i_in.target;
                                r_found  <= 1'b0;
                                r_i      <= '0;
                                r_j      <= '0;
                                r_k      <= '0;
                                if (any_empty) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_issue <= 1'b1;
                                    r_state <= S_RUN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_RUN: begin
                    // step the walk: k fastest, then j, then i
                    if (r_issue) begin
                        if (r_k != last_a) begin
                            r_k <= r_k + IDX_W'(1);
                        end else begin
                            r_k <= '0;
                            if (r_j != last_c) begin
                                r_j <= r_j + IDX_W'(1);
                            end else begin
                                r_j <= '0;
                                if (r_i != last_b) begin
                                    r_i <= r_i + IDX_W'(1);
                                end else begin
                                    r_issue <= 1'b0;
                                end
                            end
                        end
                    end

                    if (hit) begin
                        // first hit in walk order; drop reads still in flight
                        r_found <= 1'b1;
                        r_res_b <= r_b;
                        r_res_c <= r_c;
                        r_res_a <= r_rem[VAL_W-1:0];
                        r_issue <= 1'b0;
                        r_p1_v  <= 1'b0;
                        r_p2_v  <= 1'b0;
                        r_state <= S_DONE;
                    end else if (!r_issue && !r_p1_v && !r_p2_v) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // wait for a free output register
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid    <= 1'b1;
                        r_out.found    <= r_found;
                        r_out.b_value  <= r_found ? r_res_b : '0;
                        r_out.c_value  <= r_found ? r_res_c : '0;
                        r_out.a_value  <= r_found ? r_res_a : '0;
                        r_out.overflow <= r_overflow;
                        r_state        <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
